// ===== rtl/core/uwbfr_pkg.sv =====
// ============================================================================
// uwbfr_pkg: shared types, constants and field table of the frame receiver
// Holds the frame geometry, the register map, the command and release
// structs passed between the front and back halves, and the decode table.
// ============================================================================
package uwbfr_pkg;

    localparam int FRAME_BYTES = 128;
    localparam int NUM_FIELDS  = 40;
    localparam int LAST_FIELD  = NUM_FIELDS - 1;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 7;
    localparam int IDX_W       = 6;
    localparam int VAL_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_BANKS   = 2;
    localparam int BANK_W      = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] RESET_HEADER = 8'h55;
    localparam logic [BYTE_W-1:0] RESET_MARK   = 8'h01;

    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER = 1'b0,
        REG_MARK   = 1'b1
    } cfg_reg_t;

    // Finished frame handed from the front to the back
    typedef struct packed {
        logic              is_err;
        logic [BANK_W-1:0] bank;
    } frame_cmd_t;

    // Back tells the front that a store bank is free again
    typedef struct packed {
        logic              release_en;
        logic [BANK_W-1:0] bank;
    } bank_release_t;

    // Where a field sits in the frame and how it is widened
    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [1:0]       len_m1;
        logic             sext;
    } field_info_t;

    function automatic field_info_t field_info(logic [IDX_W-1:0] f);
        field_info_t info;
        int          fi;
        fi          = int'(f);
        info.start  = POS_W'(2);
        info.len_m1 = 2'd0;
        info.sext   = 1'b0;
        priority if (fi == 0) begin
            info.start = POS_W'(2);
        end else if (fi <= 14) begin
            info.start  = POS_W'(4 + 3 * (fi - 1));
            info.len_m1 = 2'd2;
            info.sext   = 1'b1;
        end else if (fi <= 20) begin
            info.start  = POS_W'(46 + 4 * (fi - 15));
            info.len_m1 = 2'd3;
        end else if (fi <= 23) begin
            info.start  = POS_W'(82 + 2 * (fi - 21));
            info.len_m1 = 2'd1;
            info.sext   = 1'b1;
        end else if (fi <= 27) begin
            info.start  = POS_W'(88 + 4 * (fi - 24));
            info.len_m1 = 2'd3;
        end else if (fi == 28) begin
            info.start  = POS_W'(112);
            info.len_m1 = 2'd3;
        end else if (fi == 29) begin
            info.start = POS_W'(116);
        end else begin
            info.start = POS_W'(117 + (fi - 30));
        end
        return info;
    endfunction

endpackage

// ===== rtl/core/uwb_frame_receiver.sv =====
// ============================================================================
// uwb_frame_receiver: fixed-length frame deframer with additive checksum
// Front half hunts sync and stores frames; back half decodes 40 fields.
// ============================================================================
// Usage:
//  - s_ channel: one received byte per item. A new byte is taken every cycle
//    while the store bank being filled is free and the item queue has room.
//  - m_ channel: per good frame 40 field items (last on field 39); per bad
//    checksum one error item (kind 1, index 0, value 0, last 1).
//  - cfg_ channel: header and mark sync bytes, always ready.
//  - Path: a finished frame's item passes through the queue to the decoder,
//    which reads its fields from the store; an error item skips the reads.
//  - Decode: each stored byte is read on the store's single read port in an
//    issue state (address) and a capture state (registered data), and each
//    field leaves through an emit state; a good frame has 40 fields in 104 bytes.
//  - Two store banks let the next frame fill while the last one decodes.
//  - Reset: hunting for header, sync bytes 0x55/0x01, queue empty, both
//    banks free. No clearing pass; the block is ready the cycle after reset.
//  - Receiver stall: m_ holds its result; the decoder pauses, the queue fills
//    and s_ready drops once no bank or queue slot is left.
// ============================================================================
module uwb_frame_receiver #(
    parameter int FRAME_BYTES = uwbfr_pkg::FRAME_BYTES
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [uwbfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [uwbfr_pkg::BYTE_W-1:0]          cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [uwbfr_pkg::BYTE_W-1:0]          s_rx_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_kind,
    output logic [uwbfr_pkg::IDX_W-1:0]           m_field_index,
    output logic signed [uwbfr_pkg::VAL_W-1:0]    m_field_value,
    output logic                                  m_last
);

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam int AW    = uwbfr_pkg::BANK_W + CNT_W;
    localparam int DEPTH = uwbfr_pkg::NUM_BANKS * FRAME_BYTES;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [uwbfr_pkg::BYTE_W-1:0]  wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [uwbfr_pkg::BYTE_W-1:0]  rd_data;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_empty;
    uwbfr_pkg::frame_cmd_t         q_cmd;
    uwbfr_pkg::frame_cmd_t         q_head;
    uwbfr_pkg::bank_release_t      rel;

    // Sync hunt and frame collection
    uwbfr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .q_full    (q_full),
        .rel       (rel)
    );

    // Two-bank frame store
    uwbfr_ram #(
        .WIDTH(uwbfr_pkg::BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Finished-frame queue
    uwbfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // Field decode and output
    uwbfr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .rel           (rel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_field_index (m_field_index),
        .m_field_value (m_field_value),
        .m_last        (m_last)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("frame queue overflow");

    // Never fill the bank that is being decoded
    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr[AW-1] != rd_addr[AW-1]))
        else $error("store write hit the bank under decode");

    // Error result carries a fixed shape
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind) |-> (m_last && m_field_index == '0 && m_field_value == '0))
        else $error("malformed error result");

    // Field results end exactly on the last field
    a_last_field: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_kind) |->
            (m_last == (m_field_index == uwbfr_pkg::IDX_W'(uwbfr_pkg::LAST_FIELD))))
        else $error("last flag out of step with field index");

endmodule

// ===== rtl/core/uwbfr_ram.sv =====
// ============================================================================
// uwbfr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module uwbfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/uwbfr_front.sv =====
// ============================================================================
// uwbfr_front: sync hunt, byte collection and checksum
// Takes received bytes, finds header then mark, writes the whole frame into
// the current store bank and queues a decode or error item at frame end.
// ============================================================================
module uwbfr_front #(
    parameter int FRAME_BYTES = uwbfr_pkg::FRAME_BYTES,
    localparam int CNT_W      = $clog2(FRAME_BYTES),
    localparam int AW         = uwbfr_pkg::BANK_W + CNT_W
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [uwbfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uwbfr_pkg::BYTE_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [uwbfr_pkg::BYTE_W-1:0]      s_rx_byte,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [uwbfr_pkg::BYTE_W-1:0]      wr_data,
    output logic                              q_push,
    output uwbfr_pkg::frame_cmd_t             q_cmd,
    input  logic                              q_full,
    input  uwbfr_pkg::bank_release_t          rel
);

    typedef enum logic [2:0] {
        P_HUNT  = 3'b001,
        P_AWAIT = 3'b010,
        P_BODY  = 3'b100
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next;
    logic [uwbfr_pkg::BYTE_W-1:0]          sum_reg, sum_next;
    logic [uwbfr_pkg::BYTE_W-1:0]          header_reg, header_next;
    logic [uwbfr_pkg::BYTE_W-1:0]          mark_reg, mark_next;
    logic [uwbfr_pkg::BANK_W-1:0]          wbank_reg, wbank_next;
    logic [uwbfr_pkg::NUM_BANKS-1:0]       busy_reg, busy_next;
    logic                                  busy_set;
    logic                                  accept;
    logic [CNT_W-1:0]                      wr_pos;

    // Stall while the queue is full or the bank to fill is still decoding
    assign s_ready   = !q_full && !busy_reg[wbank_reg];
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign wr_addr = {wbank_reg, wr_pos};
    assign wr_data = s_rx_byte;

    // Configuration writes
    always_comb begin
        header_next = header_reg;
        mark_next   = mark_reg;
        if (cfg_valid) begin
            unique case (uwbfr_pkg::cfg_reg_t'(cfg_index))
                uwbfr_pkg::REG_HEADER: header_next = cfg_data;
                uwbfr_pkg::REG_MARK:   mark_next   = cfg_data;
                default:               header_next = header_reg;
            endcase
        end
    end

    // Sync hunt and body collection
    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        wbank_next    = wbank_reg;
        busy_set      = 1'b0;
        wr_en         = 1'b0;
        wr_pos        = '0;
        q_push        = 1'b0;
        q_cmd.is_err  = 1'b0;
        q_cmd.bank    = wbank_reg;
        if (accept) begin
            unique case (phase_reg)
                P_AWAIT: begin
                    if (s_rx_byte == mark_reg) begin
                        wr_en      = 1'b1;
                        wr_pos     = CNT_W'(1);
                        sum_next   = sum_reg + s_rx_byte;
                        cnt_next   = CNT_W'(2);
                        phase_next = P_BODY;
                    end else if (s_rx_byte == header_reg) begin
                        wr_en    = 1'b1;
                        wr_pos   = '0;
                        sum_next = s_rx_byte;
                        cnt_next = CNT_W'(1);
                    end else begin
                        phase_next = P_HUNT;
                        cnt_next   = '0;
                        sum_next   = '0;
                    end
                end
                P_BODY: begin
                    wr_en  = 1'b1;
                    wr_pos = cnt_reg;
                    if (cnt_reg != CNT_W'(FRAME_BYTES - 1)) begin
                        sum_next = sum_reg + s_rx_byte;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else begin
                        // Frame complete: queue decode or error, rehunt
                        q_push       = 1'b1;
                        q_cmd.is_err = (sum_reg != s_rx_byte);
                        phase_next   = P_HUNT;
                        cnt_next     = '0;
                        sum_next     = '0;
                        if (sum_reg == s_rx_byte) begin
                            busy_set   = 1'b1;
                            wbank_next = ~wbank_reg;
                        end
                    end
                end
                default: begin
                    if (s_rx_byte == header_reg) begin
                        wr_en      = 1'b1;
                        wr_pos     = '0;
                        sum_next   = s_rx_byte;
                        cnt_next   = CNT_W'(1);
                        phase_next = P_AWAIT;
                    end else begin
                        phase_next = P_HUNT;
                    end
                end
            endcase
        end
    end

    // Bank ownership: set on handoff, clear when the back finishes
    always_comb begin
        busy_next = busy_reg;
        if (rel.release_en) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (busy_set) begin
            busy_next[wbank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= P_HUNT;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            header_reg <= uwbfr_pkg::RESET_HEADER;
            mark_reg   <= uwbfr_pkg::RESET_MARK;
            wbank_reg  <= '0;
            busy_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            header_reg <= header_next;
            mark_reg   <= mark_next;
            wbank_reg  <= wbank_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

// ===== rtl/core/uwbfr_queue.sv =====
// ============================================================================
// uwbfr_queue: short command queue between front and back
// Small FIFO of finished-frame items so either side can stall on its own.
// ============================================================================
module uwbfr_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  uwbfr_pkg::frame_cmd_t  push_cmd,
    output logic                   full,
    input  logic                   pop,
    output uwbfr_pkg::frame_cmd_t  head,
    output logic                   empty
);

    localparam int DEPTH = uwbfr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    uwbfr_pkg::frame_cmd_t entries [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/uwbfr_back.sv =====
// ============================================================================
// uwbfr_back: field decoder and result output
// Pops queued items, reads each field's bytes from the store one at a time,
// widens them and presents results through an output register.
// ============================================================================
module uwbfr_back #(
    parameter int FRAME_BYTES = uwbfr_pkg::FRAME_BYTES,
    localparam int CNT_W      = $clog2(FRAME_BYTES),
    localparam int AW         = uwbfr_pkg::BANK_W + CNT_W
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    input  uwbfr_pkg::frame_cmd_t                 q_head,
    output logic                                  q_pop,
    output logic                                  rd_en,
    output logic [AW-1:0]                         rd_addr,
    input  logic [uwbfr_pkg::BYTE_W-1:0]          rd_data,
    output uwbfr_pkg::bank_release_t              rel,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_kind,
    output logic [uwbfr_pkg::IDX_W-1:0]           m_field_index,
    output logic signed [uwbfr_pkg::VAL_W-1:0]    m_field_value,
    output logic                                  m_last
);

    typedef enum logic [3:0] {
        B_IDLE    = 4'b0001,
        B_ISSUE   = 4'b0010,
        B_CAPTURE = 4'b0100,
        B_EMIT    = 4'b1000
    } bstate_t;

    bstate_t                           state_reg, state_next;
    uwbfr_pkg::frame_cmd_t             cmd_reg, cmd_next;
    logic [uwbfr_pkg::IDX_W-1:0]       fld_reg, fld_next;
    logic [1:0]                        byte_reg, byte_next;
    logic [uwbfr_pkg::VAL_W-1:0]       acc_reg, acc_next;
    logic                              valid_reg, valid_next;
    logic                              kind_reg, kind_next;
    logic [uwbfr_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [uwbfr_pkg::VAL_W-1:0]       val_reg, val_next;
    logic                              last_reg, last_next;
    uwbfr_pkg::field_info_t            info;
    logic [uwbfr_pkg::VAL_W-1:0]       wide_val;
    logic                              out_free;
    logic                              is_last_fld;

    assign info        = uwbfr_pkg::field_info(fld_reg);
    assign out_free    = !valid_reg || m_ready;
    assign is_last_fld = (fld_reg == uwbfr_pkg::IDX_W'(uwbfr_pkg::LAST_FIELD));
    assign rd_addr     = {cmd_reg.bank, CNT_W'(info.start) + CNT_W'(byte_reg)};

    // Widen the gathered little-endian bytes
    always_comb begin
        unique case (info.len_m1)
            2'd0: wide_val = {24'd0, acc_reg[7:0]};
            2'd1: wide_val = {{16{info.sext & acc_reg[15]}}, acc_reg[15:0]};
            2'd2: wide_val = {{8{info.sext & acc_reg[23]}}, acc_reg[23:0]};
            default: wide_val = acc_reg;
        endcase
    end

    // Sequence fetch, gather and emit
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        fld_next       = fld_reg;
        byte_next      = byte_reg;
        acc_next       = acc_reg;
        valid_next     = valid_reg && !m_ready;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rel.release_en = 1'b0;
        rel.bank       = cmd_reg.bank;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    fld_next   = '0;
                    byte_next  = '0;
                    acc_next   = '0;
                    state_next = q_head.is_err ? B_EMIT : B_ISSUE;
                end
            end
            B_ISSUE: begin
                rd_en      = 1'b1;
                state_next = B_CAPTURE;
            end
            B_CAPTURE: begin
                acc_next[8*byte_reg +: 8] = rd_data;
                if (byte_reg == info.len_m1) begin
                    state_next = B_EMIT;
                end else begin
                    byte_next  = byte_reg + 2'd1;
                    state_next = B_ISSUE;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    if (cmd_reg.is_err) begin
                        kind_next  = uwbfr_pkg::KIND_ERROR;
                        idx_next   = '0;
                        val_next   = '0;
                        last_next  = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        kind_next = uwbfr_pkg::KIND_FIELD;
                        idx_next  = fld_reg;
                        val_next  = wide_val;
                        last_next = is_last_fld;
                        byte_next = '0;
                        acc_next  = '0;
                        if (is_last_fld) begin
                            rel.release_en = 1'b1;
                            state_next     = B_IDLE;
                        end else begin
                            fld_next   = fld_reg + uwbfr_pkg::IDX_W'(1);
                            state_next = B_ISSUE;
                        end
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        fld_reg  <= fld_next;
        byte_reg <= byte_next;
        acc_reg  <= acc_next;
        kind_reg <= kind_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_kind        = kind_reg;
    assign m_field_index = idx_reg;
    assign m_field_value = val_reg;
    assign m_last        = last_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the fixed-length frame deframer
// Streams received bytes into the block and checks every decoded field and
// every checksum error against a plan row's outcome or a bench model of the
// sync hunt, frame store and field decode. A short table covers sync corner
// cases and frame extremes. Random frames, noise and broken sync sequences
// follow under random idling on both channels and several sync byte settings.
// ============================================================================
module tb_top;
    import uwbfr_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 64;
    localparam int RANDOM_BYTES = 100;
    localparam int RANDOM_FIELDS = 40;
    localparam int PLAN_ROWS    = 11;

    typedef enum logic [1:0] {
        SYNC_HUNT = 2'd0,
        SYNC_MARK = 2'd1,
        SYNC_BODY = 2'd2
    } sync_phase_t;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_FRAME = 2'd1,
        OP_CFG   = 2'd2
    } row_op_t;

    typedef enum logic [1:0] {
        FILL_ZERO = 2'd0,
        FILL_ONES = 2'd1,
        FILL_RAMP = 2'd2,
        FILL_RAND = 2'd3
    } fill_t;

    // MODEL rows are checked by the predictor, the others by the typed outcome
    typedef enum logic [2:0] {
        EXP_MODEL = 3'd0,
        EXP_NONE  = 3'd1,
        EXP_ERROR = 3'd2,
        EXP_ZEROS = 3'd3,
        EXP_ONES  = 3'd4
    } outcome_t;

    typedef struct packed {
        row_op_t             op;
        fill_t               fill;
        logic                corrupt;
        logic [BYTE_W-1:0]   val_a;
        logic [BYTE_W-1:0]   val_b;
        outcome_t            check;
    } stim_row_t;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
        logic              last;
    } result_t;

    // Directed plan: sync corner cases, frame extremes, sync byte settings
    stim_row_t plan [PLAN_ROWS] = '{
        '{OP_BYTE,  FILL_ZERO, 1'b0, 8'h00,        8'h00,      EXP_NONE},
        '{OP_BYTE,  FILL_ZERO, 1'b0, 8'hFF,        8'h00,      EXP_NONE},
        '{OP_BYTE,  FILL_ZERO, 1'b0, RESET_MARK,   8'h00,      EXP_NONE},
        '{OP_BYTE,  FILL_ZERO, 1'b0, RESET_HEADER, 8'h00,      EXP_NONE},
        '{OP_BYTE,  FILL_ZERO, 1'b0, RESET_HEADER, 8'h00,      EXP_NONE},
        '{OP_BYTE,  FILL_ZERO, 1'b0, 8'h7E,        8'h00,      EXP_NONE},
        '{OP_BYTE,  FILL_ZERO, 1'b0, RESET_HEADER, 8'h00,      EXP_MODEL},
        '{OP_FRAME, FILL_ONES, 1'b0, 8'h00,        8'h00,      EXP_ONES},
        '{OP_CFG,   FILL_ZERO, 1'b0, 8'hA5,        8'hA5,      EXP_MODEL},
        '{OP_FRAME, FILL_RAMP, 1'b1, 8'h00,        8'h00,      EXP_ERROR},
        '{OP_CFG,   FILL_ZERO, 1'b0, RESET_HEADER, RESET_MARK, EXP_MODEL}
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
    logic [BYTE_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [BYTE_W-1:0] s_rx_byte = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_kind;
    logic [IDX_W-1:0] m_field_index;
    logic signed [VAL_W-1:0] m_field_value;
    logic m_last;

    // Bench copy of the deframer state and its sync registers
    logic [BYTE_W-1:0] sync_head = RESET_HEADER;
    logic [BYTE_W-1:0] sync_mark = RESET_MARK;
    logic [BYTE_W-1:0] frame_copy [FRAME_BYTES];
    logic [POS_W-1:0]  body_pos = '0;
    logic [BYTE_W-1:0] byte_sum = '0;
    sync_phase_t       phase = SYNC_HUNT;

    result_t fields_due [$];
    result_t due_head;
    int      bytes_sent = 0;
    int      fields_predicted = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      src_fast = 1'b0;
    bit      sink_fast = 1'b0;

    uwb_frame_receiver u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_field_index (m_field_index),
        .m_field_value (m_field_value),
        .m_last        (m_last)
    );

    always #10 aclk = ~aclk;

    // Assemble one decoded field from the stored frame, little-endian
    function automatic logic [VAL_W-1:0] field_word(int f);
        int                at;
        int                nbytes;
        bit                sx;
        logic [VAL_W-1:0]  w;
        sx = 1'b0;
        nbytes = 1;
        at = f + 87;
        if (f == 0) begin
            at = 2;
        end else if (f <= 14) begin
            at = 3 * f + 1;
            nbytes = 3;
            sx = 1'b1;
        end else if (f <= 20) begin
            at = 4 * f - 14;
            nbytes = 4;
        end else if (f <= 23) begin
            at = 2 * f + 40;
            nbytes = 2;
            sx = 1'b1;
        end else if (f <= 27) begin
            at = 4 * f - 8;
            nbytes = 4;
        end else if (f == 28) begin
            at = 112;
            nbytes = 4;
        end
        w = '0;
        for (int i = 0; i < nbytes; i++) begin
            w = w | (VAL_W'(frame_copy[at + i]) << (8 * i));
        end
        if (sx && w[8 * nbytes - 1]) begin
            w = w | (32'hFFFF_FFFF << (8 * nbytes));
        end
        return w;
    endfunction

    // Advance the sync hunt and frame store by one byte, collect its results
    function automatic void advance_deframer(input logic [BYTE_W-1:0] b,
                                             ref result_t out [$]);
        result_t r;
        case (phase)
            SYNC_MARK: begin
                if (b == sync_mark) begin
                    frame_copy[1] = b;
                    byte_sum = byte_sum + b;
                    body_pos = POS_W'(2);
                    phase = SYNC_BODY;
                end else if (b == sync_head) begin
                    frame_copy[0] = b;
                    byte_sum = b;
                    body_pos = POS_W'(1);
                end else begin
                    phase = SYNC_HUNT;
                    body_pos = '0;
                    byte_sum = '0;
                end
            end
            SYNC_BODY: begin
                frame_copy[body_pos] = b;
                if (body_pos != POS_W'(FRAME_BYTES - 1)) begin
                    byte_sum = byte_sum + b;
                    body_pos = body_pos + 1'b1;
                end else begin
                    if (byte_sum == b) begin
                        for (int f = 0; f < NUM_FIELDS; f++) begin
                            r.kind  = KIND_FIELD;
                            r.idx   = IDX_W'(f);
                            r.value = field_word(f);
                            r.last  = (f == LAST_FIELD);
                            out.push_back(r);
                        end
                    end else begin
                        r.kind  = KIND_ERROR;
                        r.idx   = '0;
                        r.value = '0;
                        r.last  = 1'b1;
                        out.push_back(r);
                    end
                    phase = SYNC_HUNT;
                    body_pos = '0;
                    byte_sum = '0;
                end
            end
            default: begin
                if (b == sync_head) begin
                    frame_copy[0] = b;
                    byte_sum = b;
                    body_pos = POS_W'(1);
                    phase = SYNC_MARK;
                end else begin
                    phase = SYNC_HUNT;
                end
            end
        endcase
    endfunction

    // Bias random bytes toward the extremes
    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Hand one byte over; on acceptance run the predictor on it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed);
        result_t got [$];
        int      gap;
        gap = src_fast ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_deframer(b, got);
        if (!typed) begin
            foreach (got[i]) fields_due.push_back(got[i]);
            fields_predicted += got.size();
        end
        bytes_sent++;
        if ($urandom_range(0, 63) == 0) src_fast = !src_fast;
    endtask

    // Send a full frame under the current sync bytes
    task automatic send_frame(input fill_t fill, input bit corrupt, input bit typed);
        logic [BYTE_W-1:0] fr [FRAME_BYTES];
        logic [BYTE_W-1:0] acc;
        fr[0] = sync_head;
        fr[1] = sync_mark;
        acc = sync_head + sync_mark;
        for (int i = 2; i < FRAME_BYTES - 1; i++) begin
            case (fill)
                FILL_ZERO: fr[i] = 8'h00;
                FILL_ONES: fr[i] = 8'hFF;
                FILL_RAMP: fr[i] = BYTE_W'(i);
                default:   fr[i] = rand_byte();
            endcase
            acc = acc + fr[i];
        end
        fr[FRAME_BYTES - 1] = corrupt ? acc + BYTE_W'($urandom_range(1, 255)) : acc;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            send_byte(fr[i], typed);
        end
    endtask

    // Queue the outcome written into a plan row
    task automatic push_typed(input outcome_t check);
        result_t r;
        case (check)
            EXP_ERROR: begin
                r.kind  = KIND_ERROR;
                r.idx   = '0;
                r.value = '0;
                r.last  = 1'b1;
                fields_due.push_back(r);
            end
            EXP_ZEROS, EXP_ONES: begin
                for (int f = 0; f < NUM_FIELDS; f++) begin
                    r.kind = KIND_FIELD;
                    r.idx  = IDX_W'(f);
                    r.last = (f == LAST_FIELD);
                    if (check == EXP_ZEROS) begin
                        r.value = '0;
                    end else begin
                        // id, status and user bytes are zero-extended
                        r.value = (f == 0 || f >= 29) ? 32'd255 : 32'hFFFF_FFFF;
                    end
                    fields_due.push_back(r);
                end
            end
            default: begin
            end
        endcase
    endtask

    // Hold the sender until every result is out and the block has settled
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (fields_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT / 2) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [BYTE_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (r == REG_HEADER) begin
            sync_head = d;
        end else begin
            sync_mark = d;
        end
    endtask

    task automatic set_sync(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] m);
        hold_until_drained();
        write_reg(REG_HEADER, h);
        write_reg(REG_MARK, m);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed plan, then random frames, noise and broken sync
    initial begin : source
        int                 pick;
        logic [BYTE_W-1:0]  b;
        logic [BYTE_W-1:0]  h;
        int                 byte_goal;
        int                 field_goal;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].op)
                OP_CFG: set_sync(plan[i].val_a, plan[i].val_b);
                OP_BYTE: send_byte(plan[i].val_a, plan[i].check != EXP_MODEL);
                default: begin
                    send_frame(plan[i].fill, plan[i].corrupt, plan[i].check != EXP_MODEL);
                    push_typed(plan[i].check);
                end
            endcase
        end

        byte_goal  = bytes_sent + RANDOM_BYTES;
        field_goal = fields_predicted + RANDOM_FIELDS;
        while (bytes_sent < byte_goal || fields_predicted < field_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame(FILL_RAND, 1'b0, 1'b0);
            end else if (pick < 65) begin
                send_frame(FILL_RAND, 1'b1, 1'b0);
            end else if (pick < 75) begin
                // header, maybe repeated, then a byte that breaks sync
                send_byte(sync_head, 1'b0);
                if ($urandom_range(0, 1) == 1) send_byte(sync_head, 1'b0);
                do b = BYTE_W'($urandom_range(0, 255));
                while (b == sync_head || b == sync_mark);
                send_byte(b, 1'b0);
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 6)) send_byte(rand_byte(), 1'b0);
            end else if (pick < 94) begin
                hold_until_drained();
            end else begin
                h = rand_byte();
                set_sync(h, ($urandom_range(0, 3) == 0) ? h : rand_byte());
            end
        end
        s_valid <= 1'b0;

        while (fields_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (mismatches == 0 && fields_due.size() == 0) begin
            $display("PASS uwb_frame_receiver");
        end else begin
            $display("FAIL uwb_frame_receiver");
        end
        $finish;
    end

    // Result side: random backpressure with stretches of none
    initial begin : sink
        int gap;
        forever begin
            gap = sink_fast ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            if ($urandom_range(0, 63) == 0) sink_fast = !sink_fast;
        end
    end

    // Compare each accepted result with the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fields_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: kind %0d index %0d value %h last %0d",
                             m_kind, m_field_index, m_field_value, m_last);
                end
            end else begin
                due_head = fields_due.pop_front();
                if (m_kind !== due_head.kind || m_field_index !== due_head.idx ||
                    m_field_value !== due_head.value || m_last !== due_head.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: want kind %0d index %0d value %h last %0d",
                                 due_head.kind, due_head.idx, due_head.value, due_head.last);
                        $display("                 got  kind %0d index %0d value %h last %0d",
                                 m_kind, m_field_index, m_field_value, m_last);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves an item for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d results due",
                     idle_cycles, fields_due.size());
            $display("FAIL uwb_frame_receiver");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/uwbfr_pkg.sv
rtl/core/uwbfr_ram.sv
rtl/core/uwbfr_front.sv
rtl/core/uwbfr_queue.sv
rtl/core/uwbfr_back.sv
rtl/core/uwb_frame_receiver.sv
dv/tb_top.sv
